>>> rtl/lru_page_cache_defines.svh
// Assertion macros for the LRU page cache.
// Included by the top level; the macros expect signals named clk and rst in scope.
`ifndef LRU_PAGE_CACHE_DEFINES_SVH
`define LRU_PAGE_CACHE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/lpc_pkg.sv
// Shared types and constants for the LRU page cache.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package lpc_pkg;

  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 32;

  localparam int PAGE_W   = 32;
  localparam int FRAME_W  = 4;
  localparam int STATUS_W = 3;
  localparam int CAP_W    = 5;
  localparam int APB_AW   = 2;
  localparam int APB_DW   = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET     = 5'd16;
  localparam logic [APB_AW-1:0] ADDR_CAPACITY = 2'd0;

  localparam logic OP_GET   = 1'b0;
  localparam logic OP_INVAL = 1'b1;

  localparam logic [STATUS_W-1:0] ST_HIT         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LOADED      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_READ_FAIL   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INVALIDATED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_PRESENT = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // look up the request on the ports and latch the outcome
    logic commit;   // apply the state update and register the result
  } cmd_t;

endpackage

>>> rtl/lpc_ctrl.sv
// Request sequencer for the LRU page cache: lookup cycle, then update cycle.
// Depends on lpc_pkg.
`timescale 1ns / 1ps

module lpc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output lpc_pkg::cmd_t cmd
);
  import lpc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_UPDATE = 2'b10
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state == S_UPDATE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.commit;
    end
  end

endmodule

>>> rtl/lpc_datapath.sv
// Frame store, rank store, tag compare, replacement and result registers.
// Depends on lpc_pkg; driven by the command struct from lpc_ctrl.
`timescale 1ns / 1ps

module lpc_datapath #(
  parameter int FRAMES    = lpc_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lpc_pkg::PAGE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lpc_pkg::cmd_t                 cmd,
  input  logic [lpc_pkg::CAP_W-1:0]     capacity,
  input  logic                          operation,
  input  logic [lpc_pkg::PAGE_W-1:0]    page_number,
  input  logic                          read_ok,
  output logic [lpc_pkg::STATUS_W-1:0]  status,
  output logic [lpc_pkg::FRAME_W-1:0]   frame,
  output logic                          evicted,
  output logic [lpc_pkg::PAGE_W-1:0]    evicted_page
);
  import lpc_pkg::*;

  localparam int KEEP  = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
  localparam int IW    = $clog2(FRAMES);
  localparam int CW    = $clog2(FRAMES + 1);
  localparam int CMP_W = (CW > CAP_W) ? CW : CAP_W;

  // Frame contents; entries are only read while their frame is valid.
  logic [KEEP-1:0] page_mem [FRAMES];
  logic [FRAMES-1:0] valid;
  logic [IW-1:0]     rank [FRAMES];
  logic [CW-1:0]     count;

  // Lookup against the request on the ports.
  logic [KEEP-1:0]   key;
  logic [FRAMES-1:0] match;
  logic [FRAMES-1:0] lru_hot;
  logic              hit_any;
  logic [IW-1:0]     hit_idx;
  logic [IW-1:0]     lru_idx;
  logic [IW-1:0]     oldest_rank;
  logic [CMP_W-1:0]  cap_w;
  logic [CMP_W-1:0]  cap_eff;
  logic [CMP_W-1:0]  count_w;
  logic              full;

  // Lookup outcome held for the update cycle.
  logic              op_r;
  logic              ok_r;
  logic [KEEP-1:0]   key_r;
  logic              hit_r;
  logic [IW-1:0]     hit_idx_r;
  logic [IW-1:0]     lru_idx_r;
  logic              full_r;

  // Update cycle.
  logic [FRAMES-1:0] valid_next;
  logic [FRAMES-1:0] valid_kept;
  logic [IW-1:0]     rank_next [FRAMES];
  logic [CW-1:0]     count_next;
  logic [CW-1:0]     count_kept;
  logic [IW-1:0]     hit_rank;
  logic              do_evict;
  logic              free_found;
  logic [IW-1:0]     free_idx;
  logic              load_we;
  logic [STATUS_W-1:0] status_next;
  logic [IW-1:0]     frame_idx;

  assign key         = KEEP'(page_number);
  assign oldest_rank = IW'(count - CW'(1));
  assign cap_w       = CMP_W'(capacity);
  assign count_w     = CMP_W'(count);

  always_comb begin
    hit_idx = '0;
    lru_idx = '0;
    for (int i = 0; i < FRAMES; i++) begin
      match[i]   = valid[i] && (page_mem[i] == key);
      // Ranks of valid frames are a permutation of 0..count-1.
      lru_hot[i] = valid[i] && (rank[i] == oldest_rank);
      if (match[i]) hit_idx = IW'(i);
      if (lru_hot[i]) lru_idx = IW'(i);
    end
    hit_any = |match;
    if (cap_w == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_w > CMP_W'(FRAMES)) begin
      cap_eff = CMP_W'(FRAMES);
    end else begin
      cap_eff = cap_w;
    end
    full = (count_w >= cap_eff) && (count != '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= operation;
      ok_r      <= read_ok;
      key_r     <= key;
      hit_r     <= hit_any;
      hit_idx_r <= hit_idx;
      lru_idx_r <= lru_idx;
      full_r    <= full;
    end
  end

  assign hit_rank = rank[hit_idx_r];
  assign do_evict = (op_r == OP_GET) && !hit_r && full_r;

  always_comb begin
    valid_next  = valid;
    rank_next   = rank;
    count_next  = count;
    valid_kept  = valid;
    count_kept  = count;
    free_found  = 1'b0;
    free_idx    = '0;
    load_we     = 1'b0;
    frame_idx   = '0;
    status_next = ST_NOT_PRESENT;
    if (op_r == OP_INVAL) begin
      if (hit_r) begin
        for (int i = 0; i < FRAMES; i++) begin
          if (valid[i] && (rank[i] > hit_rank)) rank_next[i] = rank[i] - IW'(1);
        end
        valid_next[hit_idx_r] = 1'b0;
        rank_next[hit_idx_r]  = '0;
        count_next            = count - CW'(1);
        status_next           = ST_INVALIDATED;
      end
    end else if (hit_r) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (valid[i] && (IW'(i) != hit_idx_r) && (rank[i] < hit_rank)) begin
          rank_next[i] = rank[i] + IW'(1);
        end
      end
      rank_next[hit_idx_r] = '0;
      status_next          = ST_HIT;
      frame_idx            = hit_idx_r;
    end else begin
      // The victim holds the oldest rank, so no other rank moves when it leaves.
      if (do_evict) begin
        valid_kept[lru_idx_r] = 1'b0;
        rank_next[lru_idx_r]  = '0;
        count_kept            = count - CW'(1);
      end
      for (int i = FRAMES - 1; i >= 0; i--) begin
        if (!valid_kept[i]) begin
          free_found = 1'b1;
          free_idx   = IW'(i);
        end
      end
      valid_next  = valid_kept;
      count_next  = count_kept;
      status_next = ST_READ_FAIL;
      if (ok_r && free_found) begin
        for (int i = 0; i < FRAMES; i++) begin
          if (valid_kept[i]) rank_next[i] = rank[i] + IW'(1);
        end
        valid_next[free_idx] = 1'b1;
        rank_next[free_idx]  = '0;
        count_next           = count_kept + CW'(1);
        load_we              = 1'b1;
        status_next          = ST_LOADED;
        frame_idx            = free_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      for (int i = 0; i < FRAMES; i++) rank[i] <= '0;
    end else if (cmd.commit) begin
      valid <= valid_next;
      count <= count_next;
      rank  <= rank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && load_we) page_mem[free_idx] <= key_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status       <= status_next;
      frame        <= FRAME_W'(frame_idx);
      evicted      <= do_evict;
      evicted_page <= do_evict ? PAGE_W'(page_mem[lru_idx_r]) : '0;
    end
  end

endmodule

>>> rtl/lru_page_cache.sv
// Top level of the fully associative LRU page cache: APB register, controller, datapath.
// Depends on lpc_pkg, lpc_ctrl, lpc_datapath and lru_page_cache_defines.svh.
//
//   Channel   Signals                                     Handshake
//   request   operation, page_number, read_ok             start & !busy
//   result    status, frame, evicted, evicted_page        done, one cycle, no stall
//   register  psel, penable, pwrite, paddr, pwdata, ...   APB setup and access, pready high
//
// A request is handled as a lookup, then an update: the cycle it is accepted compares the page
// against every frame at once, and the next cycle updates the ranks and frames. busy is high
// in that update cycle, and the result beat shows on done in the cycle after it, when a new
// request may already be accepted; no new request is accepted while busy.
// Synchronous reset empties every frame and sets capacity to 16; no clearing pass.
`timescale 1ns / 1ps

`include "lru_page_cache_defines.svh"

module lru_page_cache #(
  parameter int FRAMES    = lpc_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lpc_pkg::PAGE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [lpc_pkg::PAGE_W-1:0]    page_number,
  input  logic                          read_ok,
  output logic                          done,
  output logic [lpc_pkg::STATUS_W-1:0]  status,
  output logic [lpc_pkg::FRAME_W-1:0]   frame,
  output logic                          evicted,
  output logic [lpc_pkg::PAGE_W-1:0]    evicted_page,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpc_pkg::APB_AW-1:0]    paddr,
  input  logic [lpc_pkg::APB_DW-1:0]    pwdata,
  output logic [lpc_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import lpc_pkg::*;

  logic [CAP_W-1:0] capacity;
  cmd_t             cmd;
  logic             miss_status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_CAPACITY) ? APB_DW'(capacity) : '0;

  lpc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  lpc_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .capacity     (capacity),
    .operation    (operation),
    .page_number  (page_number),
    .read_ok      (read_ok),
    .status       (status),
    .frame        (frame),
    .evicted      (evicted),
    .evicted_page (evicted_page)
  );

  assign miss_status = (status == ST_LOADED) || (status == ST_READ_FAIL);

  `LPC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not go busy")
  `LPC_ASSERT_NEXT(a_busy_done, busy, done && !busy, "update cycle gave no result beat")
  `LPC_ASSERT_SAME(a_evict_miss, done && evicted, miss_status, "eviction without a miss")
  `LPC_ASSERT_SAME(a_no_evict_page, done && !evicted, evicted_page == '0, "stray evicted page")

endmodule
